@@ sv/deq_pkg.sv @@
// Package for the double-ended queue block.
// Holds the channel payload structs, function and status codes and the state type.
// No dependencies.
package deq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 8;

    localparam int FUNC_W   = 3;
    localparam int VALUE_W  = 8;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_BACK  = 3'd0,
        FN_PUSH_FRONT = 3'd1,
        FN_POP_FRONT  = 3'd2,
        FN_POP_BACK   = 3'd3,
        FN_CLEAR      = 3'd4
    } t_deq_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY_POP = 2'd1,
        ST_FULL_PUSH = 2'd2
    } t_deq_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } t_deq_state;

    // Request payload
    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [VALUE_W-1:0] data_in;
    } t_deq_in;

    // Result payload
    typedef struct packed {
        logic [VALUE_W-1:0]  front_value;
        logic [VALUE_W-1:0]  back_value;
        logic                not_empty;
        logic [COUNT_W-1:0]  count;
        logic [STATUS_W-1:0] status;
    } t_deq_out;

    // Controller to result stage: what to assemble in the read cycle
    typedef struct packed {
        logic                load;
        logic                not_empty;
        logic [COUNT_W-1:0]  count;
        t_deq_status         status;
        logic                fwd_front;
        logic                fwd_back;
    } t_deq_rsp;

endpackage

@@ sv/deq_mem.sv @@
// Slot storage for the double-ended queue: one write port, two read ports.
// Read data is registered; a read returns the old data on a
// same-address write. Depends on nothing.
module deq_mem #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DATA_WIDTH-1:0]    i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic [DATA_WIDTH-1:0]    o_rd_data_a,
    output logic [DATA_WIDTH-1:0]    o_rd_data_b
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_a;
    logic [DATA_WIDTH-1:0] r_rd_b;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read ports
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

@@ sv/deq_ctrl.sv @@
// Pointer and sequencing logic for the double-ended queue.
// Updates head and count, drives the slot memory and flags write-to-read forwarding.
// Depends on deq_pkg.
module deq_ctrl #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  deq_pkg::t_deq_in         i_in_item,
    input  logic                     i_out_busy,
    output logic                     o_wr_en,
    output logic [$clog2(DEPTH)-1:0] o_wr_addr,
    output logic [DATA_WIDTH-1:0]    o_wr_data,
    output logic                     o_rd_en,
    output logic [$clog2(DEPTH)-1:0] o_rd_front,
    output logic [$clog2(DEPTH)-1:0] o_rd_back,
    output logic [DATA_WIDTH-1:0]    o_fwd_data,
    output deq_pkg::t_deq_rsp        o_rsp
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    deq_pkg::t_deq_state  r_state, n_state;
    logic [IW-1:0]        r_head, n_head;
    logic [CW-1:0]        r_count, n_count;
    deq_pkg::t_deq_status r_status, n_status;
    logic                 r_fwd_front, r_fwd_back;
    logic [DATA_WIDTH-1:0] r_fwd_data;

    logic          acc;
    logic          is_full;
    logic          is_empty;
    logic [IW-1:0] head_prev;
    logic [IW-1:0] head_next;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [IW-1:0] rd_back;

    // Slot index of an offset from a head index, wrapped once
    function automatic logic [IW-1:0] slot_at(input logic [IW-1:0] head,
                                              input logic [CW-1:0] offset);
        logic [SW-1:0] sum;
        sum = SW'(head) + SW'(offset);
        if (sum >= SW'(DEPTH)) begin
            sum = sum - SW'(DEPTH);
        end
        return IW'(sum);
    endfunction

    assign is_full   = (r_count == CW'(DEPTH));
    assign is_empty  = (r_count == '0);
    assign head_prev = (r_head == '0) ? IW'(DEPTH - 1) : r_head - 1'b1;
    assign head_next = (r_head == IW'(DEPTH - 1)) ? '0 : r_head + 1'b1;

    // Accept only when idle and the result register is free by the next edge
    assign o_in_stall = !((r_state == deq_pkg::S_IDLE) && !i_out_busy);
    assign acc        = i_in_valid && !o_in_stall;

    // Next state and outputs
    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_count  = r_count;
        n_status = deq_pkg::ST_OK;
        wr_en    = 1'b0;
        wr_addr  = slot_at(r_head, r_count);

        case (i_in_item.func)
            deq_pkg::FN_PUSH_BACK: begin
                if (is_full) begin
                    n_status = deq_pkg::ST_FULL_PUSH;
                end else begin
                    wr_en   = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            deq_pkg::FN_PUSH_FRONT: begin
                if (is_full) begin
                    n_status = deq_pkg::ST_FULL_PUSH;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = head_prev;
                    n_head  = head_prev;
                    n_count = r_count + 1'b1;
                end
            end
            deq_pkg::FN_POP_FRONT: begin
                if (is_empty) begin
                    n_status = deq_pkg::ST_EMPTY_POP;
                end else begin
                    n_head  = head_next;
                    n_count = r_count - 1'b1;
                end
            end
            deq_pkg::FN_POP_BACK: begin
                if (is_empty) begin
                    n_status = deq_pkg::ST_EMPTY_POP;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            deq_pkg::FN_CLEAR: begin
                n_head  = '0;
                n_count = '0;
            end
            default: begin
            end
        endcase

        case (r_state)
            deq_pkg::S_IDLE: begin
                if (acc) begin
                    n_state = deq_pkg::S_READ;
                end
            end
            deq_pkg::S_READ: begin
                n_state = deq_pkg::S_IDLE;
            end
            default: begin
                n_state = deq_pkg::S_IDLE;
            end
        endcase
    end

    // Back slot after the request; any in-range index when the queue ends empty
    assign rd_back = (n_count == '0) ? n_head : slot_at(n_head, n_count - 1'b1);

    // Memory access
    assign o_wr_en    = acc && wr_en;
    assign o_wr_addr  = wr_addr;
    assign o_wr_data  = DATA_WIDTH'(i_in_item.data_in);
    assign o_rd_en    = acc;
    assign o_rd_front = n_head;
    assign o_rd_back  = rd_back;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= deq_pkg::S_IDLE;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (acc) begin
                r_head  <= n_head;
                r_count <= n_count;
            end
        end
    end

    // Hold status and forwarding info for the read cycle
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_status    <= n_status;
            r_fwd_front <= o_wr_en && (wr_addr == n_head);
            r_fwd_back  <= o_wr_en && (wr_addr == rd_back);
            r_fwd_data  <= o_wr_data;
        end
    end

    assign o_fwd_data      = r_fwd_data;
    assign o_rsp.load      = (r_state == deq_pkg::S_READ);
    assign o_rsp.not_empty = (r_count != '0);
    assign o_rsp.count     = deq_pkg::COUNT_W'(r_count);
    assign o_rsp.status    = r_status;
    assign o_rsp.fwd_front = r_fwd_front;
    assign o_rsp.fwd_back  = r_fwd_back;

    // Count never passes the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("element count above capacity");

    // A full queue never takes a push write
    a_no_write_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_full |-> !o_wr_en)
        else $error("slot write into a full queue");

endmodule

@@ sv/double_ended_queue.sv @@
// Double-ended queue over a ring of DEPTH slots: push back, push front, pop front,
// pop back and clear, each answered with front, back, count and status. At the accepting
// edge head and count advance, the slot memory is written and the front and back slots
// are read; in the next cycle the registered read data (or the just-written value) is
// assembled into the output register. Input is stalled in that read cycle and while a
// result waits stalled in the output register, so at most one item is in flight. The
// slots are not cleared after reset; only written slots are ever shown.
module double_ended_queue #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  deq_pkg::t_deq_in  i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output deq_pkg::t_deq_out o_out_item
);

    localparam int IW = $clog2(DEPTH);

    logic                  wr_en;
    logic [IW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  rd_en;
    logic [IW-1:0]         rd_front;
    logic [IW-1:0]         rd_back;
    logic [DATA_WIDTH-1:0] front_data;
    logic [DATA_WIDTH-1:0] back_data;
    logic [DATA_WIDTH-1:0] fwd_data;
    deq_pkg::t_deq_rsp     rsp;

    logic                  r_out_valid, n_out_valid;
    deq_pkg::t_deq_out     r_out, n_out;
    logic                  out_busy;

    assign out_busy = r_out_valid && i_out_stall;

    deq_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .i_out_busy (out_busy),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_rd_en    (rd_en),
        .o_rd_front (rd_front),
        .o_rd_back  (rd_back),
        .o_fwd_data (fwd_data),
        .o_rsp      (rsp)
    );

    deq_mem #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mem (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_rd_en     (rd_en),
        .i_rd_addr_a (rd_front),
        .i_rd_addr_b (rd_back),
        .o_rd_data_a (front_data),
        .o_rd_data_b (back_data)
    );

    // Assemble the result, taking the just-written value where the read missed it
    always_comb begin
        n_out           = r_out;
        n_out_valid     = r_out_valid && i_out_stall;
        if (rsp.load) begin
            n_out_valid       = 1'b1;
            n_out.not_empty   = rsp.not_empty;
            n_out.count       = rsp.count;
            n_out.status      = rsp.status;
            n_out.front_value = '0;
            n_out.back_value  = '0;
            if (rsp.not_empty) begin
                n_out.front_value = rsp.fwd_front ? deq_pkg::VALUE_W'(fwd_data)
                                                  : deq_pkg::VALUE_W'(front_data);
                n_out.back_value  = rsp.fwd_back ? deq_pkg::VALUE_W'(fwd_data)
                                                 : deq_pkg::VALUE_W'(back_data);
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // A result never overwrites one that is still held
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp.load |-> !r_out_valid)
        else $error("result loaded over a pending transfer");

    // Every accepted request is answered in the next cycle
    a_acc_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> rsp.load)
        else $error("accepted request not answered");

    // Not-empty flag agrees with the count
    a_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.not_empty == (r_out.count != '0)))
        else $error("not_empty disagrees with count");

endmodule

@@ sim/double_ended_queue_tb.sv @@
// Self-checking testbench for the double-ended queue block.
// Drives push, pop and clear transfers, predicts each result and checks it field by field.
// Depends on deq_pkg and double_ended_queue.
`timescale 1ns / 100ps

module double_ended_queue_tb;
    import deq_pkg::*;

    localparam int RING_DEPTH   = DEPTH_DEF;
    localparam int PTR_W        = $clog2(RING_DEPTH);
    localparam int RANDOM_ITEMS = 650;
    localparam int TAIL_ITEMS   = 100;
    localparam int DRAIN_CYCLES = 8;
    localparam int IDLE_LIMIT   = 1000;

    // Codes outside the defined operations; the block must ignore them
    localparam logic [FUNC_W-1:0] FN_UNUSED_LO = 3'd5;
    localparam logic [FUNC_W-1:0] FN_UNUSED_MID = 3'd6;
    localparam logic [FUNC_W-1:0] FN_UNUSED_HI = 3'd7;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_in_valid = 1'b0;
    logic     o_in_stall;
    t_deq_in  i_in_item = '0;
    logic     o_out_valid;
    logic     i_out_stall = 1'b0;
    t_deq_out o_out_item;

    // Predictor state
    logic [VALUE_W-1:0] ring [RING_DEPTH];
    logic [PTR_W-1:0]   head_ptr = '0;
    logic [COUNT_W-1:0] fill_cnt = '0;

    t_deq_in  pending_reqs[$];
    t_deq_out expected_results[$];

    int  mismatch_cnt = 0;
    int  idle_cycles = 0;
    int  in_gap = 0;
    int  out_hold = 0;
    int  in_idle_pct = 0;
    int  out_idle_pct = 0;
    int  pct_timer = 0;
    bit  in_fire = 1'b0;
    bit  tail_phase;

    double_ended_queue u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #6 i_clk = ~i_clk;

    assign tail_phase = (pending_reqs.size() < TAIL_ITEMS);

    function automatic t_deq_in make_req(logic [FUNC_W-1:0] fn, logic [VALUE_W-1:0] value);
        t_deq_in req;
        req.func    = fn;
        req.data_in = value;
        return req;
    endfunction

    // Apply one request to the predicted ring and return the result it should produce
    function automatic t_deq_out apply_deque_req(t_deq_in req);
        t_deq_out    res;
        t_deq_status st;
        logic [PTR_W-1:0] idx;
        st = ST_OK;
        case (req.func)
            FN_PUSH_BACK: begin
                if (fill_cnt == RING_DEPTH) begin
                    st = ST_FULL_PUSH;
                end else begin
                    idx = head_ptr + fill_cnt[PTR_W-1:0];
                    ring[idx] = req.data_in;
                    fill_cnt = fill_cnt + 1'b1;
                end
            end
            FN_PUSH_FRONT: begin
                if (fill_cnt == RING_DEPTH) begin
                    st = ST_FULL_PUSH;
                end else begin
                    head_ptr = head_ptr - 1'b1;
                    ring[head_ptr] = req.data_in;
                    fill_cnt = fill_cnt + 1'b1;
                end
            end
            FN_POP_FRONT: begin
                if (fill_cnt == 0) begin
                    st = ST_EMPTY_POP;
                end else begin
                    head_ptr = head_ptr + 1'b1;
                    fill_cnt = fill_cnt - 1'b1;
                end
            end
            FN_POP_BACK: begin
                if (fill_cnt == 0) begin
                    st = ST_EMPTY_POP;
                end else begin
                    fill_cnt = fill_cnt - 1'b1;
                end
            end
            FN_CLEAR: begin
                fill_cnt = '0;
                head_ptr = '0;
            end
            default: ;
        endcase

        if (fill_cnt == 0) begin
            res.front_value = '0;
            res.back_value  = '0;
            res.not_empty   = 1'b0;
        end else begin
            idx = head_ptr + fill_cnt[PTR_W-1:0] - 1'b1;
            res.front_value = ring[head_ptr];
            res.back_value  = ring[idx];
            res.not_empty   = 1'b1;
        end
        res.count  = fill_cnt;
        res.status = st;
        return res;
    endfunction

    task automatic check_field(string name, logic [VALUE_W-1:0] exp_v, logic [VALUE_W-1:0] act_v);
        if (act_v !== exp_v) begin
            mismatch_cnt++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
        end
    endtask

    // Stimulus: directed corner cases, then shaped random runs
    initial begin
        int seg;
        int run_len;
        int pct;
        logic [VALUE_W-1:0] value;

        pending_reqs.push_back(make_req(FN_POP_FRONT, 8'h3C));
        pending_reqs.push_back(make_req(FN_POP_BACK, 8'hC3));
        pending_reqs.push_back(make_req(FN_CLEAR, 8'hFF));
        pending_reqs.push_back(make_req(FN_UNUSED_LO, 8'h81));
        pending_reqs.push_back(make_req(FN_UNUSED_HI, 8'h7E));
        pending_reqs.push_back(make_req(FN_PUSH_FRONT, 8'hFF));
        pending_reqs.push_back(make_req(FN_PUSH_BACK, 8'h00));
        // fill to the brim, alternating ends
        for (int k = 0; k < RING_DEPTH - 2; k++) begin
            pending_reqs.push_back(make_req(k[0] ? FN_PUSH_FRONT : FN_PUSH_BACK,
                                            VALUE_W'(8'h10 + k)));
        end
        pending_reqs.push_back(make_req(FN_PUSH_BACK, 8'hA5));
        pending_reqs.push_back(make_req(FN_PUSH_FRONT, 8'h5A));
        pending_reqs.push_back(make_req(FN_POP_BACK, 8'h00));
        pending_reqs.push_back(make_req(FN_POP_FRONT, 8'hFF));
        pending_reqs.push_back(make_req(FN_UNUSED_MID, 8'h55));
        pending_reqs.push_back(make_req(FN_CLEAR, 8'h00));

        // Random runs: fill, drain, mixed, and occasional noise
        while (pending_reqs.size() < 25 + RANDOM_ITEMS) begin
            seg = $urandom_range(0, 9);
            if (seg == 9) begin
                run_len = $urandom_range(1, 3);
                for (int k = 0; k < run_len; k++) begin
                    pending_reqs.push_back(make_req($urandom_range(0, 1) ? FN_CLEAR
                        : FUNC_W'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI)),
                        VALUE_W'($urandom_range(0, 255))));
                end
            end else begin
                run_len = $urandom_range(4, 22);
                for (int k = 0; k < run_len; k++) begin
                    pct = $urandom_range(0, 99);
                    case ($urandom_range(0, 7))
                        0: value = 8'h00;
                        1: value = 8'hFF;
                        default: value = VALUE_W'($urandom_range(0, 255));
                    endcase
                    if ((seg <= 3 && pct < 85) || (seg >= 4 && seg <= 6 && pct < 15)
                        || (seg >= 7 && pct < 50)) begin
                        pending_reqs.push_back(make_req($urandom_range(0, 1) ? FN_PUSH_BACK
                            : FN_PUSH_FRONT, value));
                    end else begin
                        pending_reqs.push_back(make_req($urandom_range(0, 1) ? FN_POP_FRONT
                            : FN_POP_BACK, value));
                    end
                end
            end
        end

        // Hold reset, then release on a falling edge
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for all transfers to go through, then watch for stray results
        @(posedge i_clk);
        while (pending_reqs.size() != 0 || i_in_valid || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Re-pick idling density now and then, so busy and quiet stretches both occur
    always @(negedge i_clk) begin
        if (pct_timer == 0) begin
            pct_timer    <= 50;
            in_idle_pct  <= $urandom_range(0, 2) * 20;
            out_idle_pct <= $urandom_range(0, 2) * 20;
        end else begin
            pct_timer <= pct_timer - 1;
        end
    end

    // Request driver: advance to the next item only after a transfer
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_fire)) begin
            if (tail_phase) begin
                in_gap = 0;
            end else if (in_gap == 0 && $urandom_range(0, 99) < in_idle_pct) begin
                in_gap = $urandom_range(1, 12);
            end
            if (in_gap > 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                i_in_valid <= 1'b1;
                i_in_item  <= pending_reqs.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result stall driver: random bursts, none in the tail
    always @(negedge i_clk) begin
        if (!i_rst_n || tail_phase) begin
            out_hold = 0;
            i_out_stall <= 1'b0;
        end else begin
            if (out_hold == 0 && $urandom_range(0, 99) < out_idle_pct) begin
                out_hold = $urandom_range(1, 12);
            end
            if (out_hold > 0) begin
                out_hold--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Monitor: check results against the oldest prediction, then predict new transfers
    always @(posedge i_clk) begin
        t_deq_out exp_r;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    mismatch_cnt++;
                    $display("%0t: unexpected result, expected none, actual %0h",
                             $time, o_out_item);
                end else begin
                    exp_r = expected_results.pop_front();
                    check_field("front_value", exp_r.front_value, o_out_item.front_value);
                    check_field("back_value", exp_r.back_value, o_out_item.back_value);
                    check_field("not_empty", VALUE_W'(exp_r.not_empty),
                                VALUE_W'(o_out_item.not_empty));
                    check_field("count", VALUE_W'(exp_r.count), VALUE_W'(o_out_item.count));
                    check_field("status", VALUE_W'(exp_r.status),
                                VALUE_W'(o_out_item.status));
                end
            end
            if (i_in_valid && !o_in_stall) begin
                expected_results.push_back(apply_deque_req(i_in_item));
            end
            in_fire <= i_in_valid && !o_in_stall;
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("== FAIL ==");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule
